// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// clocked implication checks used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define CHK_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

// next-cycle implication, held off during reset
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

`endif

// ----- sv/alfr_pkg.sv -----
// ----------------------------------------------------------------------------
// alfr_pkg
// shared widths, constants and types of the additive feedback generator
// ----------------------------------------------------------------------------
`default_nettype none

package alfr_pkg;

  localparam int WORD_W     = 32;
  localparam int IDX_W      = 6;
  localparam int OUT_W      = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam int MAX_DEGREE_DEF = 63;
  localparam int MIN_DEGREE     = 7;
  localparam int LCG_DISCARD    = 50;
  localparam int DISCARD_FACTOR = 10;

  localparam logic [IDX_W-1:0] DEGREE_RST = 6'd31;
  localparam logic [IDX_W-1:0] SEP_RST    = 6'd3;
  localparam logic [IDX_W-1:0] FRONT_RST  = 6'd3;

  localparam logic [WORD_W-1:0] RESET_SEED  = 32'd1;
  // pre-reduction modulus and its double
  localparam logic [WORD_W-1:0] PM_PRE_MOD  = 32'h7fff_fffe;
  localparam logic [WORD_W-1:0] PM_PRE_MOD2 = 32'hffff_fffc;
  // mersenne modulus 2^31-1 and the minimal-standard multiplier
  localparam logic [30:0]       PM_MOD      = 31'h7fff_ffff;
  localparam logic [14:0]       PM_MULT     = 15'd16807;

  localparam logic [CFG_IDX_W-1:0] CFG_LCG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP      = 2'd2;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } tbl_wr_t;

endpackage

`default_nettype wire

// ----- sv/additive_lagged_fibonacci_rng.sv -----
// ----------------------------------------------------------------------------
// additive_lagged_fibonacci_rng
// additive feedback random generator with a park-miller single-word mode
// ----------------------------------------------------------------------------
// Pulse start while busy is low to transfer a request: func 1 asks for the
// next number, func 0 reseeds from seed_value. A next request gives one
// random_value, shown for exactly one cycle with result_valid high; there is
// no way to hold it off, so sample it on that cycle. A seed request gives no
// result. A table-mode next reads the rear word, then the front word, and
// writes their sum back; an lcg-mode next reads word 0, launches the
// park-miller unit and waits for its result. The result strobe comes on the
// first cycle with busy low. A table-mode seed writes word 0, fills words 1
// to d-1 through the park-miller unit for effective degree d and runs ten
// warm-up steps per word; an lcg-mode seed writes word 0 and runs
// LCG_DISCARD warm-up steps. After reset the block clears all MAX_DEGREE
// table words, one per cycle, and then seeds itself with 1 at degree 31.
// Configuration writes are always taken (cfg_ready is tied high) and should
// only be made while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

module additive_lagged_fibonacci_rng
  import alfr_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
)
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request side
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  func,
  input  wire logic [WORD_W-1:0]     seed_value,
  // result side
  output logic                       result_valid,
  output logic      [OUT_W-1:0]      random_value,
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // counter covers the clearing sweep, the fill index and the discard count
  localparam int CNT_W = $clog2(DISCARD_FACTOR * MAX_DEGREE + 1);

  // sequencer states
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_CLEAR     = 4'd1;
  localparam logic [3:0] ST_SEED_W0   = 4'd2;
  localparam logic [3:0] ST_FILL_PM   = 4'd3;
  localparam logic [3:0] ST_FILL_WAIT = 4'd4;
  localparam logic [3:0] ST_NX_RDR    = 4'd5;
  localparam logic [3:0] ST_NX_RDF    = 4'd6;
  localparam logic [3:0] ST_NX_ADD    = 4'd7;
  localparam logic [3:0] ST_LC_RD     = 4'd8;
  localparam logic [3:0] ST_LC_PM     = 4'd9;
  localparam logic [3:0] ST_LC_WAIT   = 4'd10;

  logic [3:0]        state;
  logic [CNT_W-1:0]  cnt;
  logic              discard;     // current next is a warm-up step, no result

  // configuration registers
  logic              lcg_mode;
  logic [IDX_W-1:0]  table_degree;
  logic [IDX_W-1:0]  tap_separation;

  // table indices
  logic [IDX_W-1:0]  front_index;
  logic [IDX_W-1:0]  rear_index;

  // payload registers
  logic [WORD_W-1:0] seed;
  logic [WORD_W-1:0] prev;        // last word of the fill chain
  logic [WORD_W-1:0] opa;         // rear word of a table add

  // derived values
  logic [IDX_W-1:0]  deg_eff;
  logic [IDX_W-1:0]  sep_eff;
  logic [IDX_W-1:0]  f_slot;
  logic [IDX_W-1:0]  r_slot;
  logic [IDX_W-1:0]  f_adv;
  logic [IDX_W-1:0]  r_adv;
  logic [IDX_W-1:0]  f_wrap;
  logic [IDX_W-1:0]  r_wrap;
  logic [CNT_W-1:0]  disc_total;
  logic [WORD_W-1:0] sum;

  // table and park-miller unit hookup
  tbl_wr_t           tbl_wr;
  logic [IDX_W-1:0]  rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              pm_start;
  logic [WORD_W-1:0] pm_operand;
  logic              pm_done;
  logic [WORD_W-1:0] pm_result;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // clamp degree into the supported range, separation below the degree
  always_comb begin
    deg_eff = table_degree;
    if (table_degree < IDX_W'(MIN_DEGREE)) begin
      deg_eff = IDX_W'(MIN_DEGREE);
    end else if (table_degree > IDX_W'(MAX_DEGREE)) begin
      deg_eff = IDX_W'(MAX_DEGREE);
    end
    sep_eff = tap_separation;
    if (tap_separation == '0) begin
      sep_eff = IDX_W'(1);
    end
    if (sep_eff >= deg_eff) begin
      sep_eff = deg_eff - IDX_W'(1);
    end
  end

  // an index past the table addresses word 0
  assign f_slot = (front_index < IDX_W'(MAX_DEGREE)) ? front_index : '0;
  assign r_slot = (rear_index  < IDX_W'(MAX_DEGREE)) ? rear_index  : '0;

  // each index wraps on its own when it reaches the degree
  assign f_adv  = f_slot + IDX_W'(1);
  assign r_adv  = r_slot + IDX_W'(1);
  assign f_wrap = (f_adv >= deg_eff) ? '0 : f_adv;
  assign r_wrap = (r_adv >= deg_eff) ? '0 : r_adv;

  // ten warm-up steps per table word, constant multiply
  assign disc_total = CNT_W'(deg_eff) * CNT_W'(DISCARD_FACTOR);

  // feedback add, modulo 2^32; rd_data holds the front word in ST_NX_ADD
  assign sum = rd_data + opa;

  // memory ports and unit start, decoded from the state
  always_comb begin
    tbl_wr     = '0;
    rd_addr    = '0;
    pm_start   = 1'b0;
    pm_operand = prev;
    unique case (state)
      ST_CLEAR: begin
        tbl_wr.en   = 1'b1;
        tbl_wr.addr = cnt[IDX_W-1:0];
        tbl_wr.data = '0;
      end
      ST_SEED_W0: begin
        tbl_wr.en   = 1'b1;
        tbl_wr.addr = '0;
        tbl_wr.data = seed;
      end
      ST_FILL_PM: begin
        pm_start   = 1'b1;
        pm_operand = prev;
      end
      ST_FILL_WAIT: begin
        if (pm_done) begin
          tbl_wr.en   = 1'b1;
          tbl_wr.addr = cnt[IDX_W-1:0];
          tbl_wr.data = pm_result;
        end
      end
      ST_NX_RDR: begin
        rd_addr = r_slot;
      end
      ST_NX_RDF: begin
        rd_addr = f_slot;
      end
      ST_NX_ADD: begin
        tbl_wr.en   = 1'b1;
        tbl_wr.addr = f_slot;
        tbl_wr.data = sum;
      end
      ST_LC_RD: begin
        rd_addr = '0;
      end
      ST_LC_PM: begin
        pm_start   = 1'b1;
        pm_operand = rd_data;
      end
      ST_LC_WAIT: begin
        if (pm_done) begin
          tbl_wr.en   = 1'b1;
          tbl_wr.addr = '0;
          tbl_wr.data = pm_result;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      cnt            <= '0;
      discard        <= 1'b0;
      result_valid   <= 1'b0;
      front_index    <= FRONT_RST;
      rear_index     <= '0;
      lcg_mode       <= 1'b0;
      table_degree   <= DEGREE_RST;
      tap_separation <= SEP_RST;
    end else begin
      result_valid <= 1'b0;

      // register writes, unknown indices are dropped
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_LCG_MODE: lcg_mode       <= cfg_data[0];
          CFG_DEGREE:   table_degree   <= cfg_data;
          CFG_SEP:      tap_separation <= cfg_data;
          default: begin
          end
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (start) begin
            discard <= 1'b0;
            if (func) begin
              state <= lcg_mode ? ST_LC_RD : ST_NX_RDR;
            end else begin
              seed  <= seed_value;
              state <= ST_SEED_W0;
            end
          end
        end
        // zero every word once after reset, then seed with one
        ST_CLEAR: begin
          if (cnt == CNT_W'(MAX_DEGREE - 1)) begin
            seed  <= RESET_SEED;
            cnt   <= '0;
            state <= ST_SEED_W0;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_SEED_W0: begin
          prev    <= seed;
          discard <= 1'b1;
          if (lcg_mode) begin
            cnt   <= CNT_W'(LCG_DISCARD);
            state <= ST_LC_RD;
          end else begin
            cnt   <= CNT_W'(1);
            state <= ST_FILL_PM;
          end
        end
        ST_FILL_PM: begin
          state <= ST_FILL_WAIT;
        end
        // chained fill of words 1 to d-1, then the warm-up run
        ST_FILL_WAIT: begin
          if (pm_done) begin
            prev <= pm_result;
            if (cnt + CNT_W'(1) == CNT_W'(deg_eff)) begin
              front_index <= sep_eff;
              rear_index  <= '0;
              cnt         <= disc_total;
              state       <= ST_NX_RDR;
            end else begin
              cnt   <= cnt + CNT_W'(1);
              state <= ST_FILL_PM;
            end
          end
        end
        ST_NX_RDR: begin
          state <= ST_NX_RDF;
        end
        ST_NX_RDF: begin
          opa   <= rd_data;
          state <= ST_NX_ADD;
        end
        ST_NX_ADD: begin
          front_index  <= f_wrap;
          rear_index   <= r_wrap;
          random_value <= sum[WORD_W-1:1];
          if (discard) begin
            if (cnt == CNT_W'(1)) begin
              discard <= 1'b0;
              state   <= ST_IDLE;
            end else begin
              cnt   <= cnt - CNT_W'(1);
              state <= ST_NX_RDR;
            end
          end else begin
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        ST_LC_RD: begin
          state <= ST_LC_PM;
        end
        ST_LC_PM: begin
          state <= ST_LC_WAIT;
        end
        ST_LC_WAIT: begin
          if (pm_done) begin
            random_value <= pm_result[OUT_W-1:0];
            if (discard) begin
              if (cnt == CNT_W'(1)) begin
                discard <= 1'b0;
                state   <= ST_IDLE;
              end else begin
                cnt   <= cnt - CNT_W'(1);
                state <= ST_LC_RD;
              end
            end else begin
              result_valid <= 1'b1;
              state        <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  alfr_table #(
    .DEPTH (MAX_DEGREE)
  ) u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  alfr_pm u_pm (
    .clk     (clk),
    .rst     (rst),
    .start   (pm_start),
    .operand (pm_operand),
    .done    (pm_done),
    .result  (pm_result)
  );

endmodule

`default_nettype wire

// ----- sv/alfr_pm.sv -----
// ----------------------------------------------------------------------------
// alfr_pm
// park-miller step unit; operand, product, fold and result are registered in turn from start to done
// ----------------------------------------------------------------------------
`default_nettype none

module alfr_pm
  import alfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] operand,
  output logic                   done,
  output logic      [WORD_W-1:0] result
);

  logic [WORD_W-1:0] reduced;
  logic [30:0]       x;
  logic [30:0]       x_next;
  logic [45:0]       prod;
  logic [31:0]       fold;
  logic [31:0]       folded;
  logic [3:0]        vld;

  // bring the word below 0x7ffffffe, at most one subtraction of the modulus or its double
  always_comb begin
    if (operand >= PM_PRE_MOD2) begin
      reduced = operand - PM_PRE_MOD2;
    end else if (operand >= PM_PRE_MOD) begin
      reduced = operand - PM_PRE_MOD;
    end else begin
      reduced = operand;
    end
    x_next = reduced[30:0] + 31'd1;
  end

  // fold sum is below twice the modulus
  assign folded = (fold >= {1'b0, PM_MOD}) ? fold - {1'b0, PM_MOD} : fold;

  always_ff @(posedge clk) begin
    x      <= x_next;
    prod   <= 46'(x) * 46'(PM_MULT);
    fold   <= {1'b0, prod[30:0]} + {17'd0, prod[45:31]};
    result <= folded - 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], start};
    end
  end

  assign done = vld[3];

endmodule

`default_nettype wire

// ----- sv/alfr_table.sv -----
// ----------------------------------------------------------------------------
// alfr_table
// feedback table memory, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module alfr_table
  import alfr_pkg::*;
#(
  parameter int DEPTH = MAX_DEGREE_DEF
)
(
  input  wire logic              clk,
  input  wire tbl_wr_t           wr,
  input  wire logic [IDX_W-1:0]  rd_addr,
  output logic      [WORD_W-1:0] rd_data
);

  localparam int ADDR_W = $clog2(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[ADDR_W-1:0]] <= wr.data;
    end
    rd_data <= mem[rd_addr[ADDR_W-1:0]];
  end

endmodule

`default_nettype wire

// ----- sv/alfr_checker.sv -----
// ----------------------------------------------------------------------------
// alfr_checker
// port-level checks on the generator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module alfr_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic func,
  input wire logic result_valid,
  input wire logic cfg_valid,
  input wire logic cfg_ready
);

  // a transferred request always occupies the sequencer
  `CHK_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

  // every request passes several sequencer states before its strobe, so strobes never touch
  `CHK_NEXT(a_strobe_single, clk, rst, result_valid, !result_valid)

  // a result only ever closes a busy stretch
  `CHK_IMPL(a_result_after_busy, clk, rst, result_valid, $past(busy))

  // a seed never produces a result straight away
  `CHK_NEXT(a_seed_silent, clk, rst, start && !busy && !func, !result_valid)

  // configuration writes are never refused
  `CHK_IMPL(a_cfg_ready, clk, rst, cfg_valid, cfg_ready)

endmodule

bind additive_lagged_fibonacci_rng alfr_checker u_checker (.*);

`default_nettype wire
